@@ rtl/x86_msr_and_tsc_executor_macros.svh @@
// Assertion helpers for the register executor.
`ifndef X86_MSR_AND_TSC_EXECUTOR_MACROS_SVH
`define X86_MSR_AND_TSC_EXECUTOR_MACROS_SVH

// Same-cycle implication, off during reset.
`define XMSR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define XMSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/xmsr_pkg.sv @@
package xmsr_pkg;

    localparam int PHYS_ADDR_BITS_DEF = 36;

    localparam logic [31:0] REG_TSC          = 32'h0000_0010;
    localparam logic [31:0] REG_APIC_BASE    = 32'h0000_001b;
    localparam logic [31:0] REG_MICROCODE    = 32'h0000_008b;
    localparam logic [31:0] REG_SYSENTER_CS  = 32'h0000_0174;
    localparam logic [31:0] REG_SYSENTER_EIP = 32'h0000_0176;
    localparam logic [31:0] REG_MTRR_CAP     = 32'h0000_0250;
    localparam logic [31:0] REG_MTRR_FIX64K  = 32'h0000_0258;
    localparam logic [31:0] REG_MTRR_FIX16K  = 32'h0000_0259;
    localparam logic [31:0] REG_MTRR_FIX4K_LO = 32'h0000_0268;
    localparam logic [31:0] REG_MTRR_FIX4K_HI = 32'h0000_026f;
    localparam logic [63:0] APIC_CLEAR_BITS  = 64'h0000_0000_0000_06ff;

    localparam int SYSENTER_COUNT = 3;

    typedef enum logic [1:0] {
        MODE_RDTSC = 2'd0,
        MODE_RDMSR = 2'd1,
        MODE_WRMSR = 2'd2,
        MODE_BAD   = 2'd3
    } xmsr_mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_READ  = 2'd1,
        ST_BAD_WRITE = 2'd2,
        ST_BAD_OP    = 2'd3
    } xmsr_status_t;

    typedef struct packed {
        xmsr_mode_t  mode;
        logic [31:0] reg_index;
        logic [63:0] write_value;
        logic [63:0] host_count;
        logic [31:0] instr_pointer;
        logic [3:0]  instr_length;
    } xmsr_cmd_t;

    typedef struct packed {
        logic [63:0]  read_value;
        xmsr_status_t status;
        logic [31:0]  next_pointer;
    } xmsr_rsp_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } xmsr_ctl_t;

endpackage

@@ rtl/xmsr_ctrl.sv @@
module xmsr_ctrl
    import xmsr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      done,
    output xmsr_ctl_t ctl
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;
    logic   done_reg;
    logic   done_next;
    logic   accept;

    assign accept = start && !busy_reg;

    always_comb
    begin
        state_next = state_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                    busy_next  = 1'b1;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign ctl.load = accept;
    assign ctl.exec = (state_reg == S_EXEC);

endmodule

@@ rtl/xmsr_dp.sv @@
module xmsr_dp
    import xmsr_pkg::*;
#(
    parameter int PHYS_ADDR_BITS = PHYS_ADDR_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  xmsr_ctl_t ctl,
    input  xmsr_cmd_t cmd,
    output xmsr_rsp_t rsp
);

    xmsr_cmd_t                 cmd_reg;
    xmsr_rsp_t                 rsp_reg;
    xmsr_rsp_t                 rsp_next;
    logic [63:0]               offset_reg;
    logic [63:0]               offset_next;
    logic [31:0]               sysenter_reg [SYSENTER_COUNT];
    logic [PHYS_ADDR_BITS-1:0] apic_reg;
    logic [PHYS_ADDR_BITS-1:0] apic_next;

    logic [63:0] tsc_now;
    logic [1:0]  sys_sel;
    logic        is_tsc;
    logic        is_sys;
    logic        is_apic;
    logic        is_zero;
    logic        wr_offset;
    logic        wr_sys;
    logic        wr_apic;

    assign tsc_now = offset_reg + cmd_reg.host_count;
    assign sys_sel = cmd_reg.reg_index[1:0];
    assign is_tsc  = (cmd_reg.reg_index == REG_TSC);
    assign is_apic = (cmd_reg.reg_index == REG_APIC_BASE);
    assign is_sys  = (cmd_reg.reg_index >= REG_SYSENTER_CS)
                  && (cmd_reg.reg_index <= REG_SYSENTER_EIP);
    assign is_zero = (cmd_reg.reg_index == REG_MICROCODE)
                  || (cmd_reg.reg_index == REG_MTRR_CAP)
                  || (cmd_reg.reg_index == REG_MTRR_FIX64K)
                  || (cmd_reg.reg_index == REG_MTRR_FIX16K)
                  || ((cmd_reg.reg_index >= REG_MTRR_FIX4K_LO)
                      && (cmd_reg.reg_index <= REG_MTRR_FIX4K_HI));

    assign offset_next = cmd_reg.write_value - cmd_reg.host_count;
    assign apic_next   = cmd_reg.write_value[PHYS_ADDR_BITS-1:0]
                       & ~APIC_CLEAR_BITS[PHYS_ADDR_BITS-1:0];

    always_comb
    begin
        rsp_next.read_value = cmd_reg.write_value;
        rsp_next.status     = ST_OK;
        wr_offset           = 1'b0;
        wr_sys              = 1'b0;
        wr_apic             = 1'b0;
        case (cmd_reg.mode)
            MODE_RDTSC:
            begin
                rsp_next.read_value = tsc_now;
            end
            MODE_RDMSR:
            begin
                if (is_tsc)
                    rsp_next.read_value = tsc_now;
                else if (is_sys)
                    rsp_next.read_value = {32'd0, sysenter_reg[sys_sel]};
                else if (is_apic)
                    rsp_next.read_value = {{(64 - PHYS_ADDR_BITS){1'b0}}, apic_reg};
                else if (is_zero)
                    rsp_next.read_value = 64'd0;
                else
                    rsp_next.status = ST_BAD_READ;
            end
            MODE_WRMSR:
            begin
                if (is_tsc)
                    wr_offset = 1'b1;
                else if (is_sys)
                    wr_sys = 1'b1;
                else if (is_apic)
                    wr_apic = 1'b1;
                else
                    rsp_next.status = ST_BAD_WRITE;
            end
            default:
            begin
                rsp_next.status = ST_BAD_OP;
            end
        endcase
        // on error hold the pointer
        if (rsp_next.status == ST_OK)
            rsp_next.next_pointer = cmd_reg.instr_pointer
                                  + {28'd0, cmd_reg.instr_length};
        else
            rsp_next.next_pointer = cmd_reg.instr_pointer;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            cmd_reg <= cmd;
        if (ctl.exec)
            rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= 64'd0;
            apic_reg   <= '0;
            for (int i = 0; i < SYSENTER_COUNT; i++)
                sysenter_reg[i] <= 32'd0;
        end
        else if (ctl.exec)
        begin
            if (wr_offset)
                offset_reg <= offset_next;
            if (wr_apic)
                apic_reg <= apic_next;
            if (wr_sys)
                sysenter_reg[sys_sel] <= cmd_reg.write_value[31:0];
        end
    end

    assign rsp = rsp_reg;

endmodule

@@ rtl/x86_msr_and_tsc_executor.sv @@
// Executes RDTSC, RDMSR and WRMSR for one virtual CPU.
// Command channel: drive cmd and raise start; the beat is taken at a rising
// edge where start is high and busy is low. busy rises the cycle after and
// stays high for one cycle while the datapath executes.
// Result channel: done is high for exactly one cycle, after the execute
// state, with the result beat on rsp. The receiver cannot stall;
// it must take the beat in that cycle.
// A new command is taken only while busy is low. The edge that ends the done
// cycle may already accept the next command. Each command first registers
// its fields, then does the 64-bit time-counter add/subtract and register
// update.
// Reset (rst_n low, asynchronous) clears the time offset, the SYSENTER
// registers and the APIC base, and returns the controller to idle.
// Register reads of the microcode and MTRR numbers return zero; writes to
// them, unknown registers and unknown operations report an error status,
// leave the state alone and return the pointer unchanged.
module x86_msr_and_tsc_executor
    import xmsr_pkg::*;
#(
    parameter int PHYS_ADDR_BITS = PHYS_ADDR_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  xmsr_cmd_t cmd,
    output logic      done,
    output xmsr_rsp_t rsp
);

    xmsr_ctl_t ctl;

    xmsr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl)
    );

    xmsr_dp #(
        .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .cmd   (cmd),
        .rsp   (rsp)
    );

`include "x86_msr_and_tsc_executor_macros.svh"

    `XMSR_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "busy not raised after accept")
    `XMSR_ASSERT_NEXT(a_accept_done, clk, rst_n, start && !busy, ##1 done, "result not strobed two cycles after accept")
    `XMSR_ASSERT_IMPLY(a_done_idle, clk, rst_n, done, !busy, "result strobed while busy")
    `XMSR_ASSERT_IMPLY(a_err_ptr, clk, rst_n, done && rsp.status != ST_OK, rsp.next_pointer == $past(cmd.instr_pointer, 2), "pointer moved on error")

endmodule

@@ dv/tb_x86_msr_and_tsc_executor.sv @@
`timescale 1ns / 1ps

module tb_x86_msr_and_tsc_executor;
    import xmsr_pkg::*;

    localparam int PHYS_BITS    = PHYS_ADDR_BITS_DEF;
    localparam int RANDOM_ITEMS = 1025;
    localparam int CALM_TAIL    = 150;
    localparam int CYCLE_LIMIT  = 200000;

    // Predicts each result from its own copy of the architectural state and
    // checks results in order against the predictions.
    class msr_result_checker;
        logic [63:0]  tsc_offset;
        logic [31:0]  sysenter_val [SYSENTER_COUNT];
        logic [63:0]  apic_base_val;
        xmsr_rsp_t    pending_rsps [$];
        int unsigned  errors;

        function new();
            tsc_offset    = '0;
            apic_base_val = '0;
            foreach (sysenter_val[i])
                sysenter_val[i] = '0;
            errors = 0;
        endfunction

        function int pending();
            return pending_rsps.size();
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            errors++;
        endtask

        function bit is_zero_reg(logic [31:0] idx);
            return idx == REG_MICROCODE || idx == REG_MTRR_CAP || idx == REG_MTRR_FIX64K
                || idx == REG_MTRR_FIX16K
                || (idx >= REG_MTRR_FIX4K_LO && idx <= REG_MTRR_FIX4K_HI);
        endfunction

        function bit is_sysenter_reg(logic [31:0] idx);
            return idx >= REG_SYSENTER_CS && idx <= REG_SYSENTER_EIP;
        endfunction

        // Execute one command against the local state and queue its result.
        function void note_cmd(xmsr_cmd_t c);
            xmsr_rsp_t   r;
            logic [63:0] apic_mask;
            apic_mask    = ((64'd1 << PHYS_BITS) - 64'd1) & ~APIC_CLEAR_BITS;
            r.read_value = c.write_value;
            r.status     = ST_OK;
            case (c.mode)
                MODE_RDTSC:
                    r.read_value = tsc_offset + c.host_count;
                MODE_RDMSR:
                    if (c.reg_index == REG_TSC)
                        r.read_value = tsc_offset + c.host_count;
                    else if (is_sysenter_reg(c.reg_index))
                        r.read_value = {32'd0, sysenter_val[c.reg_index - REG_SYSENTER_CS]};
                    else if (c.reg_index == REG_APIC_BASE)
                        r.read_value = apic_base_val;
                    else if (is_zero_reg(c.reg_index))
                        r.read_value = '0;
                    else
                        r.status = ST_BAD_READ;
                MODE_WRMSR:
                    if (c.reg_index == REG_TSC)
                        tsc_offset = c.write_value - c.host_count;
                    else if (is_sysenter_reg(c.reg_index))
                        sysenter_val[c.reg_index - REG_SYSENTER_CS] = c.write_value[31:0];
                    else if (c.reg_index == REG_APIC_BASE)
                        apic_base_val = c.write_value & apic_mask;
                    else
                        r.status = ST_BAD_WRITE;
                default:
                    r.status = ST_BAD_OP;
            endcase
            r.next_pointer = (r.status == ST_OK) ? c.instr_pointer + 32'(c.instr_length)
                                                 : c.instr_pointer;
            pending_rsps.push_back(r);
        endfunction

        task check_rsp(xmsr_rsp_t got);
            xmsr_rsp_t want;
            if (pending_rsps.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat %h", got));
                return;
            end
            want = pending_rsps.pop_front();
            if (got.read_value !== want.read_value)
                report_mismatch($sformatf("read_value %h, expected %h",
                                          got.read_value, want.read_value));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.next_pointer !== want.next_pointer)
                report_mismatch($sformatf("next_pointer %h, expected %h",
                                          got.next_pointer, want.next_pointer));
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       start;
    logic       busy;
    xmsr_cmd_t  cmd;
    logic       done;
    xmsr_rsp_t  rsp;
    int unsigned cycles = 0;

    msr_result_checker sb = new();

    logic [31:0] msr_ids [16] = '{
        REG_TSC, REG_APIC_BASE, REG_SYSENTER_CS, REG_SYSENTER_CS + 32'd1, REG_SYSENTER_EIP,
        REG_MICROCODE, REG_MTRR_CAP, REG_MTRR_FIX64K, REG_MTRR_FIX16K, REG_MTRR_FIX4K_LO,
        REG_MTRR_FIX4K_LO + 32'd3, REG_MTRR_FIX4K_HI, REG_SYSENTER_CS - 32'd1,
        REG_SYSENTER_EIP + 32'd1, REG_MTRR_FIX4K_LO - 32'd1, REG_MTRR_FIX4K_HI + 32'd1
    };

    x86_msr_and_tsc_executor dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_x86_msr_and_tsc_executor: FAIL");
            $finish;
        end
    end

    // Check the result beat before noting a command taken on the same edge.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done)
                sb.check_rsp(rsp);
            if (start && !busy)
                sb.note_cmd(cmd);
        end
    end

    function automatic xmsr_cmd_t mk_cmd(xmsr_mode_t m, logic [31:0] idx, logic [63:0] wval,
                                         logic [63:0] host, logic [31:0] ip, logic [3:0] len);
        xmsr_cmd_t c;
        c.mode          = m;
        c.reg_index     = idx;
        c.write_value   = wval;
        c.host_count    = host;
        c.instr_pointer = ip;
        c.instr_length  = len;
        return c;
    endfunction

    function automatic xmsr_cmd_t random_cmd();
        xmsr_cmd_t   c;
        int unsigned pick;
        c.write_value   = {$urandom(), $urandom()};
        c.host_count    = {$urandom(), $urandom()};
        c.instr_pointer = $urandom();
        c.instr_length  = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 45)
            c.mode = MODE_WRMSR;
        else if (pick < 85)
            c.mode = MODE_RDMSR;
        else if (pick < 93)
            c.mode = MODE_RDTSC;
        else
            c.mode = MODE_BAD;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            c.reg_index = msr_ids[$urandom_range(0, 15)];
        else if (pick < 90)
            c.reg_index = $urandom_range(0, 32'h300);
        else
            c.reg_index = $urandom();
        pick = $urandom_range(0, 15);
        if (pick == 0)
            c.write_value = '1;
        else if (pick == 1)
            c.write_value = '0;
        return c;
    endfunction

    // Present one command, optionally after an idle burst, and hold it until taken.
    task send_cmd(xmsr_cmd_t c, int unsigned gap);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd   <= c;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic int unsigned idle_burst();
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 9) : 0;
    endfunction

    task run_directed();
        xmsr_cmd_t dir [$];
        dir.push_back(mk_cmd(MODE_RDTSC, 32'd0, '0, '0, 32'h1000, 4'd2));
        dir.push_back(mk_cmd(MODE_RDTSC, '1, '1, '1, 32'h1000, 4'd2));
        // offset goes negative: value below host count
        dir.push_back(mk_cmd(MODE_WRMSR, REG_TSC, 64'd5, 64'd10, 32'h2000, 4'd2));
        dir.push_back(mk_cmd(MODE_RDMSR, REG_TSC, '0, 64'd3, 32'h2002, 4'd2));
        dir.push_back(mk_cmd(MODE_RDTSC, 32'd0, '0, '1, 32'h2004, 4'd2));
        dir.push_back(mk_cmd(MODE_WRMSR, REG_SYSENTER_CS, '1, '0, 32'h3000, 4'd2));
        dir.push_back(mk_cmd(MODE_WRMSR, REG_SYSENTER_CS + 32'd1,
                             64'h1234_5678_9abc_def0, '0, 32'h3002, 4'd2));
        dir.push_back(mk_cmd(MODE_WRMSR, REG_SYSENTER_EIP, 64'hffff_ffff_0000_0001, '0,
                             32'h3004, 4'd2));
        dir.push_back(mk_cmd(MODE_RDMSR, REG_SYSENTER_CS, '1, '0, 32'h3006, 4'd2));
        dir.push_back(mk_cmd(MODE_RDMSR, REG_SYSENTER_CS + 32'd1, '0, '0, 32'h3008, 4'd2));
        dir.push_back(mk_cmd(MODE_RDMSR, REG_SYSENTER_EIP, '0, '0, 32'h300a, 4'd2));
        dir.push_back(mk_cmd(MODE_WRMSR, REG_APIC_BASE, '1, '0, 32'h4000, 4'd2));
        dir.push_back(mk_cmd(MODE_RDMSR, REG_APIC_BASE, '0, '0, 32'h4002, 4'd2));
        dir.push_back(mk_cmd(MODE_RDMSR, REG_MICROCODE, '1, '0, 32'h5000, 4'd2));
        dir.push_back(mk_cmd(MODE_WRMSR, REG_MICROCODE, '1, '0, 32'h5002, 4'd2));
        dir.push_back(mk_cmd(MODE_RDMSR, REG_MTRR_CAP, '1, '0, 32'h5004, 4'd2));
        dir.push_back(mk_cmd(MODE_RDMSR, REG_MTRR_FIX64K, '1, '0, 32'h5006, 4'd2));
        dir.push_back(mk_cmd(MODE_RDMSR, REG_MTRR_FIX16K, '1, '0, 32'h5008, 4'd2));
        dir.push_back(mk_cmd(MODE_RDMSR, REG_MTRR_FIX4K_LO, '1, '0, 32'h500a, 4'd2));
        dir.push_back(mk_cmd(MODE_RDMSR, REG_MTRR_FIX4K_HI, '1, '0, 32'h500c, 4'd2));
        dir.push_back(mk_cmd(MODE_WRMSR, REG_MTRR_FIX4K_HI, '1, '0, 32'h500e, 4'd2));
        dir.push_back(mk_cmd(MODE_RDMSR, '1, '1, '0, 32'h6000, 4'd3));
        dir.push_back(mk_cmd(MODE_WRMSR, REG_SYSENTER_EIP + 32'd1, '1, '0, 32'h6000, 4'd3));
        dir.push_back(mk_cmd(MODE_BAD, REG_TSC, '1, '1, '1, 4'd15));
        // pointer wraps past the top of the address space
        dir.push_back(mk_cmd(MODE_RDTSC, 32'd0, '0, '0, '1, 4'd15));
        // zero length leaves the pointer in place
        dir.push_back(mk_cmd(MODE_RDMSR, REG_APIC_BASE, '0, '0, 32'h7000, 4'd0));
        foreach (dir[i])
            send_cmd(dir[i], idle_burst());
    endtask

    initial
    begin
        int unsigned gap;
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // hold off once until the block has returned everything
            if (i == RANDOM_ITEMS / 2)
                drain_results();
            gap = 0;
            if (i < RANDOM_ITEMS - CALM_TAIL && (i / 100) % 3 != 2)
                gap = idle_burst();
            send_cmd(random_cmd(), gap);
        end
        drain_results();
        repeat (4) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_x86_msr_and_tsc_executor: PASS");
        else
            $display("tb_x86_msr_and_tsc_executor: FAIL");
        $finish;
    end

endmodule
